[src/atma_pkg.sv]
`default_nettype none

package atma_pkg;

    // Field widths of the converter samples and of the averaged result.
    localparam int SAMPLE_W = 10;
    localparam int OUT_W    = 11;
    localparam int COUNT_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    // Default batch depth.
    localparam int MAX_SAMPLES_DEF = 8;

    // Sample limits and the temperature saturation window.
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'd1023;
    localparam int TEMP_HI = 127;
    localparam int TEMP_LO = -128;

    // Register reset values.
    localparam logic [COUNT_W-1:0]  COUNT_RST  = 4'd6;
    localparam logic                TRIM_RST   = 1'b1;
    localparam logic                KIND_RST   = 1'b0;
    localparam logic [SAMPLE_W-1:0] OFFSET_RST = 10'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_TRIM_ENABLE  = 2'd1,
        CFG_MEASURE_KIND = 2'd2,
        CFG_TEMP_OFFSET  = 2'd3
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } t_state;

    // Divider control and status.
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

[src/atma_div.sv]
`default_nettype none

// Restoring divider that retires one quotient bit per cycle.
module atma_div #(
    parameter int NUM_W = 13,
    parameter int DEN_W = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire atma_pkg::t_div_ctl   i_ctl,
    input  wire logic [NUM_W-1:0]     i_num,
    input  wire logic [DEN_W-1:0]     i_den,
    output atma_pkg::t_div_sts        o_sts,
    output logic [NUM_W-1:0]          o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W+1:0] trial;
    logic             busy;
    logic             q_bit;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        busy      = (r_cnt != '0);
        rem_shift = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, r_den};
        q_bit     = ~trial[DEN_W+1];
    end

    // Iteration counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Dividend, partial remainder and divisor.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (busy) begin
            r_q   <= {r_q[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? trial[DEN_W:0] : rem_shift;
        end
    end

    assign o_sts.busy = busy;
    assign o_sts.done = busy && (r_cnt == CNT_W'(1));
    assign o_quot     = r_q;

endmodule

`default_nettype wire

[src/adc_trimmed_mean_averager.sv]
// A sample that does not close a batch leaves the sequencer idle and ready high. A closing
// sample moves it to prep, which loads the divider and clears the batch; the divide state
// waits on the divider, which retires one quotient bit per cycle. The finish state registers
// the result once the output register is free and returns to idle. No sample is taken
// meanwhile; a finished result waits in the output register while the next batch is taken.
// Synchronous active-low reset restores the batch, the sequencer, valid flag and settings.
`default_nettype none

module adc_trimmed_mean_averager #(
    parameter int MAX_SAMPLES = atma_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [atma_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [atma_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                             i_sample_valid,
    output logic                                  o_sample_ready,
    input  wire logic [atma_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                                  o_result_valid,
    input  wire logic                             i_result_ready,
    output logic signed [atma_pkg::OUT_W-1:0]     o_average_value,
    output logic                                  o_is_temperature
);

    localparam int SW     = atma_pkg::SAMPLE_W;
    localparam int SUM_W  = $clog2(1023 * MAX_SAMPLES + 1);
    localparam int TALLY_W = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W  = (TALLY_W > atma_pkg::COUNT_W) ? TALLY_W : atma_pkg::COUNT_W;

    // Configuration registers.
    logic [atma_pkg::COUNT_W-1:0] r_sample_count;
    logic                         r_trim_enable;
    logic                         r_measure_kind;
    logic [SW-1:0]                r_temp_offset;

    // Batch accumulators.
    logic [TALLY_W-1:0] r_tally;
    logic [SUM_W-1:0]   r_sum;
    logic [SW-1:0]      r_min;
    logic [SW-1:0]      r_max;

    // Sequencer and output register.
    atma_pkg::t_state r_state, n_state;
    logic                      r_out_valid;
    logic signed [atma_pkg::OUT_W-1:0] r_avg;
    logic                      r_is_temp;

    atma_pkg::t_div_ctl div_ctl;
    atma_pkg::t_div_sts div_sts;
    logic [SUM_W-1:0]   div_quot;

    logic               accept;
    logic               out_free;
    logic [TALLY_W-1:0] tally_inc;
    logic [CMP_W-1:0]   eff_count;
    logic               closes;
    logic               trim_now;
    logic [SUM_W-1:0]   num;
    logic [TALLY_W-1:0] den;
    logic [SW-1:0]      avg;
    logic signed [SW+1:0] diff;
    logic signed [SW+1:0] temp_sat;
    logic signed [atma_pkg::OUT_W-1:0] result;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= atma_pkg::COUNT_RST;
            r_trim_enable  <= atma_pkg::TRIM_RST;
            r_measure_kind <= atma_pkg::KIND_RST;
            r_temp_offset  <= atma_pkg::OFFSET_RST;
        end else if (i_cfg_we) begin
            case (atma_pkg::t_cfg_idx'(i_cfg_index))
                atma_pkg::CFG_SAMPLE_COUNT: begin
                    r_sample_count <= i_cfg_wdata[atma_pkg::COUNT_W-1:0];
                end
                atma_pkg::CFG_TRIM_ENABLE: begin
                    r_trim_enable <= i_cfg_wdata[0];
                end
                atma_pkg::CFG_MEASURE_KIND: begin
                    r_measure_kind <= i_cfg_wdata[0];
                end
                atma_pkg::CFG_TEMP_OFFSET: begin
                    r_temp_offset <= i_cfg_wdata[SW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective batch length and batch close detection.
    always_comb begin
        accept    = i_sample_valid && o_sample_ready;
        tally_inc = r_tally + 1'b1;
        if (r_sample_count == '0) begin
            eff_count = CMP_W'(1);
        end else if (CMP_W'(r_sample_count) > CMP_W'(MAX_SAMPLES)) begin
            eff_count = CMP_W'(MAX_SAMPLES);
        end else begin
            eff_count = CMP_W'(r_sample_count);
        end
        closes = (CMP_W'(tally_inc) >= eff_count);
    end

    // Dividend and divisor, with or without the extremes dropped.
    always_comb begin
        trim_now = r_trim_enable && (r_tally >= TALLY_W'(3));
        if (trim_now) begin
            num = r_sum - SUM_W'(r_min) - SUM_W'(r_max);
            den = r_tally - TALLY_W'(2);
        end else begin
            num = r_sum;
            den = r_tally;
        end
    end

    // Batch accumulators: add each item, restart once the divider is loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
            r_sum   <= '0;
            r_min   <= atma_pkg::SAMPLE_MAX;
            r_max   <= '0;
        end else if (r_state == atma_pkg::ST_PREP) begin
            r_tally <= '0;
            r_sum   <= '0;
            r_min   <= atma_pkg::SAMPLE_MAX;
            r_max   <= '0;
        end else if (accept) begin
            r_tally <= tally_inc;
            r_sum   <= r_sum + SUM_W'(i_sample);
            if (i_sample < r_min) begin
                r_min <= i_sample;
            end
            if (i_sample > r_max) begin
                r_max <= i_sample;
            end
        end
    end

    atma_div #(
        .NUM_W (SUM_W),
        .DEN_W (TALLY_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (num),
        .i_den   (den),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    // Next state.
    always_comb begin
        out_free = !r_out_valid || i_result_ready;
        n_state  = r_state;
        case (r_state)
            atma_pkg::ST_IDLE: begin
                if (accept && closes) begin
                    n_state = atma_pkg::ST_PREP;
                end
            end
            atma_pkg::ST_PREP: begin
                n_state = atma_pkg::ST_DIV;
            end
            atma_pkg::ST_DIV: begin
                if (div_sts.done) begin
                    n_state = atma_pkg::ST_FIN;
                end
            end
            atma_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = atma_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = atma_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_sample_ready = 1'b0;
        div_ctl.start  = 1'b0;
        case (r_state)
            atma_pkg::ST_IDLE: begin
                o_sample_ready = 1'b1;
            end
            atma_pkg::ST_PREP: begin
                div_ctl.start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atma_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Clip the quotient and form the voltage or temperature result.
    always_comb begin
        if (|div_quot[SUM_W-1:SW]) begin
            avg = atma_pkg::SAMPLE_MAX;
        end else begin
            avg = div_quot[SW-1:0];
        end
        diff = $signed({2'b00, avg}) - $signed({2'b00, r_temp_offset});
        if (diff > (SW+2)'(atma_pkg::TEMP_HI)) begin
            temp_sat = (SW+2)'(atma_pkg::TEMP_HI);
        end else if (diff < (SW+2)'(atma_pkg::TEMP_LO)) begin
            temp_sat = (SW+2)'(atma_pkg::TEMP_LO);
        end else begin
            temp_sat = diff;
        end
        if (r_measure_kind) begin
            result = temp_sat[atma_pkg::OUT_W-1:0];
        end else begin
            result = {1'b0, avg};
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == atma_pkg::ST_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_result_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (r_state == atma_pkg::ST_FIN && out_free) begin
            r_avg     <= result;
            r_is_temp <= r_measure_kind;
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_average_value  = r_avg;
    assign o_is_temperature = r_is_temp;

    // The divider runs only while the sequencer waits on it.
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.busy |-> (r_state == atma_pkg::ST_DIV))
        else $error("divider busy outside the divide state");

    // The batch never holds more items than the configured maximum.
    a_tally_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally <= TALLY_W'(MAX_SAMPLES))
        else $error("batch tally above maximum");

    // A non-empty batch has its minimum at or below its maximum.
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tally != '0) |-> (r_min <= r_max))
        else $error("batch minimum above maximum");

    // Leaving the finish state always presents a result.
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == atma_pkg::ST_FIN && out_free) |=> r_out_valid)
        else $error("finished result not presented");

endmodule

`default_nettype wire
